FILE: src/np_pkg.sv
// shared types and constants for the next permutation pipeline
// no dependencies; compiled first
package np_pkg;

    localparam int MAX_ELEMS     = 8;
    localparam int ELEM_BITS     = 8;
    localparam int IDX_BITS      = $clog2(MAX_ELEMS);
    localparam int LEN_BITS      = $clog2(MAX_ELEMS + 1);
    localparam int CFG_LEN_BITS  = 4;
    localparam int SWAP_BITS     = 3;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [CFG_LEN_BITS-1:0] SEQ_LEN_RESET = CFG_LEN_BITS'(8);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SEQ_LENGTH = 1'b0
    } reg_idx_t;

    typedef logic [ELEM_BITS-1:0]                 elem_t;
    typedef logic [MAX_ELEMS-1:0][ELEM_BITS-1:0]  elem_vec_t;
    typedef logic [IDX_BITS-1:0]                  idx_t;
    typedef logic [LEN_BITS-1:0]                  len_t;
    typedef logic [CFG_LEN_BITS-1:0]              cfg_len_t;
    typedef logic [SWAP_BITS-1:0]                 swap_cnt_t;

    // after ascent compare: asc[q] set when elems[q] < elems[q+1] inside the sequence
    typedef struct packed {
        elem_vec_t                elems;
        len_t                     len;
        logic [MAX_ELEMS-2:0]     asc;
    } s1_t;

    typedef struct packed {
        elem_vec_t elems;
        len_t      len;
        idx_t      piv;
        elem_t     piv_val;
        logic      found;
    } s2_t;

    typedef struct packed {
        elem_vec_t elems;
        len_t      len;
        idx_t      piv;
        idx_t      succ;
        logic      found;
    } s3_t;

    typedef struct packed {
        elem_vec_t elems;
        swap_cnt_t swap_count;
        logic      no_next;
    } res_t;

endpackage

FILE: src/np_in_if.sv
// input channel: one sequence per request
// depends on np_pkg
interface np_in_if import np_pkg::*; ();
    logic  valid;
    logic  ready;
    elem_t in_elem_0;
    elem_t in_elem_1;
    elem_t in_elem_2;
    elem_t in_elem_3;
    elem_t in_elem_4;
    elem_t in_elem_5;
    elem_t in_elem_6;
    elem_t in_elem_7;

    modport source (
        output valid, in_elem_0, in_elem_1, in_elem_2, in_elem_3,
               in_elem_4, in_elem_5, in_elem_6, in_elem_7,
        input  ready
    );
    modport sink (
        input  valid, in_elem_0, in_elem_1, in_elem_2, in_elem_3,
               in_elem_4, in_elem_5, in_elem_6, in_elem_7,
        output ready
    );
endinterface

FILE: src/np_out_if.sv
// output channel: next permutation, swap count and no-next flag
// depends on np_pkg
interface np_out_if import np_pkg::*; ();
    logic      valid;
    logic      ready;
    elem_t     out_elem_0;
    elem_t     out_elem_1;
    elem_t     out_elem_2;
    elem_t     out_elem_3;
    elem_t     out_elem_4;
    elem_t     out_elem_5;
    elem_t     out_elem_6;
    elem_t     out_elem_7;
    swap_cnt_t swap_count;
    logic      no_next;

    modport source (
        output valid, out_elem_0, out_elem_1, out_elem_2, out_elem_3,
               out_elem_4, out_elem_5, out_elem_6, out_elem_7,
               swap_count, no_next,
        input  ready
    );
    modport sink (
        input  valid, out_elem_0, out_elem_1, out_elem_2, out_elem_3,
               out_elem_4, out_elem_5, out_elem_6, out_elem_7,
               swap_count, no_next,
        output ready
    );
endinterface

FILE: src/np_ascent.sv
// stage 1: length saturation and neighbor compares for the ascent search
// depends on np_pkg
module np_ascent import np_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  elem_vec_t up_elems,
    input  cfg_len_t  seq_length,
    output logic      up_ready,
    output logic      dn_valid,
    output s1_t       dn_data,
    input  logic      dn_ready
);

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;
    len_t len;

    always_comb
    begin
        if (int'(seq_length) > MAX_ELEMS)
        begin
            len = LEN_BITS'(MAX_ELEMS);
        end
        else
        begin
            len = LEN_BITS'(seq_length);
        end
        data_next.elems = up_elems;
        data_next.len   = len;
        for (int q = 0; q < MAX_ELEMS - 1; q++)
        begin
            // bound checked first: both neighbors inside the sequence
            data_next.asc[q] = (LEN_BITS'(q + 1) < len) && (up_elems[q] < up_elems[q + 1]);
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/np_pivot.sv
// stage 2: rightmost ascent gives the pivot index and value
// depends on np_pkg
module np_pivot import np_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  s1_t  up_data,
    output logic up_ready,
    output logic dn_valid,
    output s2_t  dn_data,
    input  logic dn_ready
);

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;
    idx_t piv;

    always_comb
    begin
        piv = '0;
        for (int q = 0; q < MAX_ELEMS - 1; q++)
        begin
            if (up_data.asc[q])
            begin
                piv = IDX_BITS'(q);
            end
        end
        data_next.elems   = up_data.elems;
        data_next.len     = up_data.len;
        data_next.piv     = piv;
        data_next.piv_val = up_data.elems[piv];
        data_next.found   = |up_data.asc;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/np_succ.sv
// stage 3: rightmost element above the pivot value, the swap partner
// depends on np_pkg
module np_succ import np_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  s2_t  up_data,
    output logic up_ready,
    output logic dn_valid,
    output s3_t  dn_data,
    input  logic dn_ready
);

    logic valid_reg;
    s3_t  data_reg;
    s3_t  data_next;
    idx_t succ;

    always_comb
    begin
        succ = up_data.piv;
        for (int k = 0; k < MAX_ELEMS; k++)
        begin
            if ((IDX_BITS'(k) > up_data.piv) && (LEN_BITS'(k) < up_data.len)
                && (up_data.piv_val < up_data.elems[k]))
            begin
                succ = IDX_BITS'(k);
            end
        end
        data_next.elems = up_data.elems;
        data_next.len   = up_data.len;
        data_next.piv   = up_data.piv;
        data_next.succ  = succ;
        data_next.found = up_data.found;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/np_reorder.sv
// stage 4: pivot swap and suffix reversal into the output register
// depends on np_pkg
module np_reorder import np_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  s3_t  up_data,
    output logic up_ready,
    output logic dn_valid,
    output res_t dn_data,
    input  logic dn_ready
);

    logic      valid_reg;
    res_t      data_reg;
    res_t      data_next;
    elem_vec_t swapped;
    len_t      span;
    int        src;

    always_comb
    begin
        swapped = up_data.elems;
        swapped[up_data.piv]  = up_data.elems[up_data.succ];
        swapped[up_data.succ] = up_data.elems[up_data.piv];
        span = up_data.len - LEN_BITS'(up_data.piv) - LEN_BITS'(1);
        src  = 0;

        data_next.elems = up_data.elems;
        if (up_data.found)
        begin
            for (int j = 0; j < MAX_ELEMS; j++)
            begin
                // suffix after the pivot is mirrored inside the sequence
                src = int'(up_data.piv) + int'(up_data.len) - j;
                if ((IDX_BITS'(j) > up_data.piv) && (LEN_BITS'(j) < up_data.len))
                begin
                    data_next.elems[j] = swapped[IDX_BITS'(src)];
                end
                else
                begin
                    data_next.elems[j] = swapped[j];
                end
            end
            data_next.swap_count = SWAP_BITS'(1 + (int'(span) >> 1));
            data_next.no_next    = 1'b0;
        end
        else
        begin
            data_next.swap_count = '0;
            data_next.no_next    = 1'b1;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/next_permutation_step_top.sv
// top level: apb register, four-stage next permutation pipeline
// depends on np_pkg, np_in_if, np_out_if and the four stage modules
//
//  channel  | kind            | carries
//  ---------+-----------------+---------------------------------------------
//  in_ch    | valid/ready     | in_elem_0..7, one sequence per request
//  out_ch   | valid/ready     | out_elem_0..7, swap_count, no_next
//  apb      | psel/penable    | seq_length at byte address 0
//
// four register stages: compare, pivot, partner, swap/reverse
// one request accepted every cycle while the first stage is not stalled
// each stage holds while the one after it is full and stalled, so a stall
// backs up stage by stage and nothing is dropped or repeated
// reset clears the valid bits and sets seq_length to 8
module next_permutation_step_top import np_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    np_in_if.sink                    in_ch,
    np_out_if.source                 out_ch
);

    cfg_len_t  seq_len_reg;
    cfg_len_t  seq_len_next;
    reg_idx_t  reg_idx;
    elem_vec_t in_elems;

    logic s1_valid, s1_ready;
    logic s2_valid, s2_ready;
    logic s3_valid, s3_ready;
    logic s4_ready;
    s1_t  s1_data;
    s2_t  s2_data;
    s3_t  s3_data;
    res_t res;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

    always_comb
    begin
        seq_len_next = seq_len_reg;
        prdata       = '0;
        unique case (reg_idx)
            REG_SEQ_LENGTH:
            begin
                prdata = APB_DATA_BITS'(seq_len_reg);
                if (psel && penable && pwrite)
                begin
                    seq_len_next = pwdata[CFG_LEN_BITS-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= SEQ_LEN_RESET;
        end
        else
        begin
            seq_len_reg <= seq_len_next;
        end
    end

    assign in_elems[0] = in_ch.in_elem_0;
    assign in_elems[1] = in_ch.in_elem_1;
    assign in_elems[2] = in_ch.in_elem_2;
    assign in_elems[3] = in_ch.in_elem_3;
    assign in_elems[4] = in_ch.in_elem_4;
    assign in_elems[5] = in_ch.in_elem_5;
    assign in_elems[6] = in_ch.in_elem_6;
    assign in_elems[7] = in_ch.in_elem_7;

    np_ascent u_ascent (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_ch.valid),
        .up_elems   (in_elems),
        .seq_length (seq_len_reg),
        .up_ready   (in_ch.ready),
        .dn_valid   (s1_valid),
        .dn_data    (s1_data),
        .dn_ready   (s1_ready)
    );

    np_pivot u_pivot (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_data  (s1_data),
        .up_ready (s1_ready),
        .dn_valid (s2_valid),
        .dn_data  (s2_data),
        .dn_ready (s2_ready)
    );

    np_succ u_succ (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_data  (s2_data),
        .up_ready (s2_ready),
        .dn_valid (s3_valid),
        .dn_data  (s3_data),
        .dn_ready (s3_ready)
    );

    np_reorder u_reorder (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_data  (s3_data),
        .up_ready (s3_ready),
        .dn_valid (out_ch.valid),
        .dn_data  (res),
        .dn_ready (s4_ready)
    );

    assign s4_ready          = out_ch.ready;
    assign out_ch.out_elem_0 = res.elems[0];
    assign out_ch.out_elem_1 = res.elems[1];
    assign out_ch.out_elem_2 = res.elems[2];
    assign out_ch.out_elem_3 = res.elems[3];
    assign out_ch.out_elem_4 = res.elems[4];
    assign out_ch.out_elem_5 = res.elems[5];
    assign out_ch.out_elem_6 = res.elems[6];
    assign out_ch.out_elem_7 = res.elems[7];
    assign out_ch.swap_count = res.swap_count;
    assign out_ch.no_next    = res.no_next;

`ifndef SYNTH
    // no-next results carry no swaps, real permutations at least one
    a_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.no_next == (out_ch.swap_count == '0)))
        else $error("swap count and no-next flag disagree");

    // stage one keeps its request while stage two is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_data)))
        else $error("stage one request lost under stall");

    // the partner lies past the pivot inside the sequence
    a_succ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid && s3_data.found) |->
            ((s3_data.succ > s3_data.piv) && (LEN_BITS'(s3_data.succ) < s3_data.len)))
        else $error("swap partner out of range");
`endif

endmodule
